>>> hw/rtl/cmw_pkg.sv
// Package for the circle map winding-number block: defaults, constants and sine table entries.
package cmw_pkg;

	localparam int unsigned DEF_STEPS_PER_ORBIT = 150;
	localparam int unsigned DEF_MAX_ORBITS      = 65536;
	localparam int unsigned DEF_SINE_ADDR_BITS  = 10;

	localparam int unsigned PHASE_W = 48;   // Q16.32 phase
	localparam int unsigned SUM_W   = 64;   // displacement accumulator
	localparam int unsigned FIELD_W = 32;   // Q4.28 operands and result

	localparam logic [63:0] HALF_PI_Q31 = 64'd3373259426;
	localparam logic [31:0] ONE_Q31     = 32'h8000_0000;

	// Quarter-wave entry i of a 2**abits table: Taylor series of sin through x^19 in Q31.
	function automatic logic [31:0] sine_entry(input int unsigned i, input int unsigned abits);
		logic [63:0]        theta;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic [63:0]        prod;
		logic signed [63:0] acc;
		theta = (HALF_PI_Q31 * 64'(i)) >> abits;
		x2    = (theta * theta) >> 31;
		term  = theta;
		acc   = signed'(theta);
		for (int k = 1; k <= 9; k++) begin
			prod = (term * x2) >> 31;
			case (k)
				1:       term = prod / 6;
				2:       term = prod / 20;
				3:       term = prod / 42;
				4:       term = prod / 72;
				5:       term = prod / 110;
				6:       term = prod / 156;
				7:       term = prod / 210;
				8:       term = prod / 272;
				default: term = prod / 342;
			endcase
			if ((k % 2) == 1) begin
				acc = acc - signed'(term);
			end else begin
				acc = acc + signed'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		if (acc > 64'sh7fff_ffff) begin
			acc = 64'sh7fff_ffff;
		end
		return acc[31:0];
	endfunction

endpackage

>>> hw/rtl/circle_map_winding_number.sv
// Sine circle map orbit engine with winding-number accumulator and divider.
//
// Usage: drive drive_freq (omega, Q4.28), coupling (K, Q4.28), start_phase
// (Q0.32) and last_orbit with start high; the transaction is taken at the
// rising edge where start is high and busy is low. The block then runs
// STEPS_PER_ORBIT map steps x += omega - K*sin(2*pi*x) on a single
// multiplier: each step is a sine-ROM read plus multiply (ST_MUL), then a
// phase add (ST_ADD) that also issues the next ROM read. The ROM read port
// and the multiplier set the step time.
// An orbit without last_orbit runs its steps and the ST_ACC sum update
// before busy drops and the next transaction can be taken.
// With last_orbit the accumulated displacement is divided by
// 16*orbits*STEPS_PER_ORBIT with a restoring divider, one quotient bit per
// cycle; after the ST_RND rounding step the result appears on
// winding/saturated with done high for exactly one cycle.
// The receiver cannot stall: done is a strobe, and the accumulators clear as
// the result goes out. saturated flags a clamped sum or result, or orbits
// dropped once MAX_ORBITS have been summed.
// Reset (arst_n low) clears the phase, step count, sum, orbit count and
// overflow flag; the sine table is a constant ROM and needs no fill.
module circle_map_winding_number
	import cmw_pkg::*;
#(
	parameter int unsigned STEPS_PER_ORBIT = DEF_STEPS_PER_ORBIT,
	parameter int unsigned MAX_ORBITS      = DEF_MAX_ORBITS,
	parameter int unsigned SINE_ADDR_BITS  = DEF_SINE_ADDR_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] drive_freq,
	input  logic signed [31:0] coupling,
	input  logic        [31:0] start_phase,
	input  logic               last_orbit,
	output logic               done,
	output logic signed [31:0] winding,
	output logic               saturated
);

	localparam int unsigned TBL_N  = 1 << SINE_ADDR_BITS;
	localparam int unsigned STEP_W = $clog2(STEPS_PER_ORBIT + 1);
	localparam int unsigned ORB_W  = $clog2(MAX_ORBITS + 1);
	localparam int unsigned DIV_W  = ORB_W + STEP_W + 4;   // orbits * steps * 16
	localparam int unsigned CNT_W  = $clog2(SUM_W);

	typedef logic [31:0] rom_arr_t [TBL_N];

	function automatic rom_arr_t build_rom();
		rom_arr_t r;
		for (int unsigned i = 0; i < TBL_N; i++) begin
			r[i] = sine_entry(i, SINE_ADDR_BITS);
		end
		return r;
	endfunction

	localparam rom_arr_t SINE_ROM = build_rom();

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD,
		ST_ACC,
		ST_PREP,
		ST_DIV,
		ST_RND
	} state_t;

	state_t                      state_q;
	logic        [STEP_W-1:0]    step_q;
	logic signed [31:0]          omega_q;
	logic signed [31:0]          kc_q;
	logic        [31:0]          start_q;
	logic                        last_q;
	logic signed [PHASE_W-1:0]   phase_q;
	logic signed [63:0]          prod_q;
	logic signed [SUM_W-1:0]     sum_q;
	logic        [ORB_W-1:0]     orbit_q;
	logic                        ovf_q;
	logic                        neg_q;
	logic        [DIV_W-1:0]     dvs_q;
	logic        [DIV_W-1:0]     rem_q;
	logic        [SUM_W-1:0]     dvd_q;
	logic        [CNT_W-1:0]     cnt_q;
	logic                        done_q;
	logic signed [31:0]          winding_q;
	logic                        saturated_q;

	// sine ROM and its lookup flags
	logic        [31:0]              rom_q;
	logic                            one_q;
	logic                            sneg_q;
	logic        [31:0]              look_frac;
	logic        [SINE_ADDR_BITS-1:0] look_j;
	logic        [SINE_ADDR_BITS-1:0] rom_addr;

	// datapath
	logic        [31:0]          sin_mag;
	logic signed [32:0]          sin_val;
	logic signed [64:0]          prod_full;
	logic signed [63:0]          prod_shr;
	logic signed [PHASE_W-1:0]   omega16;
	logic signed [PHASE_W-1:0]   phase_nxt;
	logic signed [PHASE_W-1:0]   disp;
	logic signed [SUM_W:0]       sum_ext;
	logic                        sum_ovf;
	logic        [DIV_W:0]       rem_sh;
	logic                        div_ge;
	logic        [DIV_W-1:0]     half_up;
	logic        [SUM_W-1:0]     quo_rnd;
	logic        [SUM_W-1:0]     sum_mag;

	// phase update: x += 16*omega - floor(K*sin / 2^27)
	assign omega16   = {{(PHASE_W - 36){omega_q[31]}}, omega_q, 4'b0000};
	assign prod_shr  = prod_q >>> 27;
	assign phase_nxt = phase_q + omega16 - prod_shr[PHASE_W-1:0];

	// quarter-wave addressing; odd quadrants read mirrored, j=0 there is 1.0
	assign look_frac = (state_q == ST_IDLE) ? start_phase : phase_nxt[31:0];
	assign look_j    = look_frac[29 -: SINE_ADDR_BITS];
	assign rom_addr  = look_frac[30] ? (~look_j + 1'b1) : look_j;

	always_ff @(posedge clk) begin
		rom_q  <= SINE_ROM[rom_addr];
		one_q  <= look_frac[30] && (look_j == '0);
		sneg_q <= look_frac[31];
	end

	assign sin_mag   = one_q ? ONE_Q31 : rom_q;
	assign sin_val   = sneg_q ? -signed'({1'b0, sin_mag}) : signed'({1'b0, sin_mag});
	assign prod_full = kc_q * sin_val;

	// orbit displacement into a saturating 64-bit sum
	assign disp    = phase_q - signed'({{(PHASE_W - 32){1'b0}}, start_q});
	assign sum_ext = {sum_q[SUM_W-1], sum_q}
		+ {{(SUM_W + 1 - PHASE_W){disp[PHASE_W-1]}}, disp};
	assign sum_ovf = sum_ext[SUM_W] != sum_ext[SUM_W-1];
	assign sum_mag = sum_q[SUM_W-1] ? (~sum_q + 1'b1) : sum_q;

	// restoring divider step
	assign rem_sh = {rem_q, dvd_q[SUM_W-1]};
	assign div_ge = rem_sh >= {1'b0, dvs_q};

	// round half away from zero on the magnitude
	assign half_up = dvs_q - (dvs_q >> 1);
	assign quo_rnd = dvd_q + SUM_W'(rem_q >= half_up);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			phase_q     <= '0;
			sum_q       <= '0;
			orbit_q     <= '0;
			ovf_q       <= 1'b0;
			cnt_q       <= '0;
			done_q      <= 1'b0;
			omega_q     <= '0;
			kc_q        <= '0;
			start_q     <= '0;
			last_q      <= 1'b0;
			prod_q      <= '0;
			neg_q       <= 1'b0;
			dvs_q       <= '0;
			rem_q       <= '0;
			dvd_q       <= '0;
			winding_q   <= '0;
			saturated_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						omega_q <= drive_freq;
						kc_q    <= coupling;
						start_q <= start_phase;
						last_q  <= last_orbit;
						phase_q <= signed'({{(PHASE_W - 32){1'b0}}, start_phase});
						step_q  <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q  <= prod_full[63:0];
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					phase_q <= phase_nxt;
					if (step_q == STEP_W'(STEPS_PER_ORBIT - 1)) begin
						step_q  <= '0;
						state_q <= ST_ACC;
					end else begin
						step_q  <= step_q + 1'b1;
						state_q <= ST_MUL;
					end
				end
				ST_ACC: begin
					if (orbit_q < ORB_W'(MAX_ORBITS)) begin
						if (sum_ovf) begin
							sum_q <= sum_ext[SUM_W] ? signed'({1'b1, {(SUM_W - 1){1'b0}}})
								: signed'({1'b0, {(SUM_W - 1){1'b1}}});
							ovf_q <= 1'b1;
						end else begin
							sum_q <= sum_ext[SUM_W-1:0];
						end
						orbit_q <= orbit_q + 1'b1;
					end else begin
						ovf_q <= 1'b1;
					end
					state_q <= last_q ? ST_PREP : ST_IDLE;
				end
				ST_PREP: begin
					neg_q   <= sum_q[SUM_W-1];
					dvd_q   <= sum_mag;
					rem_q   <= '0;
					dvs_q   <= (DIV_W'(orbit_q) * DIV_W'(STEPS_PER_ORBIT)) << 4;
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= div_ge ? DIV_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DIV_W-1:0];
					dvd_q <= {dvd_q[SUM_W-2:0], div_ge};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(SUM_W - 1)) begin
						state_q <= ST_RND;
					end
				end
				ST_RND: begin
					if (!neg_q) begin
						if (quo_rnd > SUM_W'(32'h7fff_ffff)) begin
							winding_q   <= 32'sh7fff_ffff;
							saturated_q <= 1'b1;
						end else begin
							winding_q   <= signed'(quo_rnd[31:0]);
							saturated_q <= ovf_q;
						end
					end else begin
						if (quo_rnd > SUM_W'(32'h8000_0000)) begin
							winding_q   <= signed'(32'h8000_0000);
							saturated_q <= 1'b1;
						end else begin
							winding_q   <= signed'(~quo_rnd[31:0] + 1'b1);
							saturated_q <= ovf_q;
						end
					end
					done_q  <= 1'b1;
					sum_q   <= '0;
					orbit_q <= '0;
					ovf_q   <= 1'b0;
					phase_q <= '0;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy      = state_q != ST_IDLE;
	assign done      = done_q;
	assign winding   = winding_q;
	assign saturated = saturated_q;

`ifndef NO_ASSERTIONS
	a_done_after_round: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == ST_RND))
		else $error("result strobe without rounding step");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe longer than one cycle");

	a_accept_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == ST_MUL && step_q == '0))
		else $error("accepted transaction did not start an orbit");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV || state_q == ST_RND) |-> (rem_q < dvs_q))
		else $error("divider remainder out of range");

	a_orbit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		orbit_q <= ORB_W'(MAX_ORBITS))
		else $error("orbit count above limit");
`endif

endmodule

>>> sim/circle_map_winding_number_tb.sv
// Testbench for circle_map_winding_number: directed and random orbits checked against a winding predictor.
module circle_map_winding_number_tb;
	import cmw_pkg::*;

	localparam int unsigned STEPS          = DEF_STEPS_PER_ORBIT;
	localparam int unsigned ORBIT_LIMIT    = DEF_MAX_ORBITS;
	localparam int unsigned ABITS          = DEF_SINE_ADDR_BITS;
	localparam int unsigned TBL_SIZE       = 1 << ABITS;
	localparam int unsigned RESULT_LATENCY = 2 * STEPS + 68;
	localparam int unsigned ITEM_TARGET    = 850;
	localparam int unsigned IDLE_PCT       = 23;
	// stretch of orbits sent back to back, no sender gaps
	localparam int unsigned BURST_LO       = 350;
	localparam int unsigned BURST_HI       = 500;

	typedef struct {
		logic signed [31:0] freq;
		logic signed [31:0] coupling;
		logic        [31:0] phase;
		logic               last;
	} orbit_req_t;

	typedef struct {
		logic signed [31:0] winding;
		logic               saturated;
	} winding_res_t;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               start       = 1'b0;
	logic signed [31:0] drive_freq  = '0;
	logic signed [31:0] coupling    = '0;
	logic        [31:0] start_phase = '0;
	logic               last_orbit  = 1'b0;
	logic               busy;
	logic               done;
	logic signed [31:0] winding;
	logic               saturated;

	// pending orbits (driver input) and winding results still owed by the block
	orbit_req_t   orbit_queue[$];
	winding_res_t winding_expected[$];

	// predictor state: quarter-wave ROM image and the per-point accumulators
	logic [31:0] quarter_sine[TBL_SIZE];
	longint      disp_sum;
	int unsigned orbits_summed;
	bit          overflow_flag;

	int unsigned orbits_sent;
	int unsigned results_checked;
	int unsigned saturations_seen;
	int unsigned fault_count;

	always #4 clk = ~clk;

	circle_map_winding_number u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.drive_freq (drive_freq),
		.coupling   (coupling),
		.start_phase(start_phase),
		.last_orbit (last_orbit),
		.done       (done),
		.winding    (winding),
		.saturated  (saturated)
	);

	// Taylor series of sin through x^19 in Q31, terms truncated at each stage
	function automatic logic [31:0] taylor_q31(input logic [63:0] theta);
		logic [63:0] x2;
		logic [63:0] term;
		longint      acc;
		x2   = (theta * theta) >> 31;
		term = theta;
		acc  = longint'(theta);
		for (int k = 1; k <= 9; k++) begin
			term = ((term * x2) >> 31) / 64'((2 * k) * (2 * k + 1));
			if (k % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		if (acc > 64'sh7fff_ffff) begin
			acc = 64'sh7fff_ffff;
		end
		return acc[31:0];
	endfunction

	// signed Q1.31 sine of a Q0.32 fraction; odd quadrants mirror the table,
	// and its first slot is exactly 1.0 since the table never reaches it
	function automatic longint sine_of(input logic [31:0] frac);
		logic [1:0]       quad;
		logic [ABITS-1:0] j;
		longint           mag;
		quad = frac[31:30];
		j    = frac[29 -: ABITS];
		if (quad[0]) begin
			mag = (j == 0) ? longint'(ONE_Q31) : longint'(quarter_sine[TBL_SIZE - j]);
		end else begin
			mag = longint'(quarter_sine[j]);
		end
		return quad[1] ? -mag : mag;
	endfunction

	// run one orbit in Q16.32; omega goes to Q.32 by x16, K*sin by floor(/2^27)
	function automatic longint orbit_displacement(input orbit_req_t req);
		longint x;
		longint s;
		x = longint'(req.phase);
		for (int n = 0; n < STEPS; n++) begin
			s = sine_of(x[31:0]);
			x = x + longint'(req.freq) * 16 - ((longint'(req.coupling) * s) >>> 27);
		end
		return x - longint'(req.phase);
	endfunction

	// fold one accepted orbit into the sums; on the last orbit of a point,
	// divide (round half away from zero), clamp, queue the result and clear
	task automatic account_orbit(input orbit_req_t req);
		longint       disp;
		longint       total;
		logic [63:0]  div;
		logic [63:0]  mag;
		logic [63:0]  q;
		bit           neg;
		winding_res_t res;
		disp = orbit_displacement(req);
		if (orbits_summed < ORBIT_LIMIT) begin
			total = disp_sum + disp;
			if (disp > 0 && total < disp_sum) begin
				disp_sum      = 64'sh7fff_ffff_ffff_ffff;
				overflow_flag = 1'b1;
			end else if (disp < 0 && total > disp_sum) begin
				disp_sum      = 64'sh8000_0000_0000_0000;
				overflow_flag = 1'b1;
			end else begin
				disp_sum = total;
			end
			orbits_summed++;
		end else begin
			// orbit-count limit: orbit dropped, flagged on the result
			overflow_flag = 1'b1;
		end
		if (!req.last) begin
			return;
		end
		div = 64'(orbits_summed) * STEPS * 16;
		neg = disp_sum < 0;
		mag = neg ? -disp_sum : disp_sum;
		q   = mag / div + (((mag % div) >= (div - div / 2)) ? 64'd1 : 64'd0);
		res.saturated = overflow_flag;
		if (!neg) begin
			if (q > 64'h7fff_ffff) begin
				q             = 64'h7fff_ffff;
				res.saturated = 1'b1;
			end
		end else begin
			if (q > 64'h8000_0000) begin
				q             = 64'h8000_0000;
				res.saturated = 1'b1;
			end
			q = -q;
		end
		res.winding = q[31:0];
		winding_expected.push_back(res);
		disp_sum      = 0;
		orbits_summed = 0;
		overflow_flag = 1'b0;
	endtask

	task automatic queue_orbit(input logic [31:0] freq, input logic [31:0] k,
			input logic [31:0] phase, input logic last);
		orbit_req_t req;
		req.freq     = freq;
		req.coupling = k;
		req.phase    = phase;
		req.last     = last;
		orbit_queue.push_back(req);
	endtask

	// extremes and round numbers of Q4.28
	function automatic logic [31:0] edge_value();
		case ($urandom_range(5))
			0:       return 32'h7fff_ffff;
			1:       return 32'h8000_0000;
			2:       return 32'h0000_0000;
			3:       return 32'hffff_ffff;
			4:       return 32'h1000_0000;
			default: return 32'hf000_0000;
		endcase
	endfunction

	// Driver: a transaction is taken at the edge where start is high and busy
	// low. The predictor runs at that edge; start then drops or moves to the
	// next orbit in one assignment. While idle the fields carry junk.
	always @(posedge clk) begin : driver
		bit go;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				account_orbit(orbit_queue.pop_front());
				orbits_sent++;
			end
			go = 1'b0;
			if (orbit_queue.size() != 0) begin
				go = (orbits_sent >= BURST_LO && orbits_sent < BURST_HI) ||
					($urandom_range(99) >= IDLE_PCT);
			end
			start <= go;
			if (go) begin
				drive_freq  <= orbit_queue[0].freq;
				coupling    <= orbit_queue[0].coupling;
				start_phase <= orbit_queue[0].phase;
				last_orbit  <= orbit_queue[0].last;
			end else begin
				drive_freq  <= $urandom;
				coupling    <= $urandom;
				start_phase <= $urandom;
				last_orbit  <= 1'($urandom_range(1));
			end
		end
	end

	// Monitor: done is a one-cycle strobe; compare with the oldest expectation
	always @(posedge clk) begin : monitor
		winding_res_t want;
		if (arst_n && done) begin
			if (winding_expected.size() == 0) begin
				fault_count++;
				if (fault_count <= 10) begin
					$display("unexpected result: winding=%h saturated=%b",
						winding, saturated);
				end
			end else begin
				want = winding_expected.pop_front();
				results_checked++;
				if (want.saturated) begin
					saturations_seen++;
				end
				if (winding !== want.winding || saturated !== want.saturated) begin
					fault_count++;
					if (fault_count <= 10) begin
						$display("mismatch on result %0d: winding exp %h got %h, saturated exp %b got %b",
							results_checked, want.winding, winding, want.saturated, saturated);
					end
				end
			end
		end
	end

	initial begin : stimulus
		int unsigned kind;
		int unsigned len;
		logic [31:0] freq;
		logic [31:0] k;

		for (int i = 0; i < TBL_SIZE; i++) begin
			quarter_sine[i] = taylor_q31((HALF_PI_Q31 * 64'(i)) >> ABITS);
		end

		// directed: zero, omega extremes with K=0 (exact, no clamp)
		queue_orbit(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
		queue_orbit(32'h7fff_ffff, 32'h0000_0000, 32'h0000_0000, 1'b1);
		queue_orbit(32'h8000_0000, 32'h0000_0000, 32'hffff_ffff, 1'b1);
		// omega and K at opposite extremes push the average past the int32 range
		queue_orbit(32'h7fff_ffff, 32'h8000_0000, 32'h4000_0000, 1'b1);
		queue_orbit(32'h8000_0000, 32'h7fff_ffff, 32'h4000_0000, 1'b1);
		// one point over four orbits, each starting on a quadrant boundary
		queue_orbit(32'h0000_0000, 32'h1000_0000, 32'h0000_0000, 1'b0);
		queue_orbit(32'h0000_0000, 32'h1000_0000, 32'h4000_0000, 1'b0);
		queue_orbit(32'h0000_0000, 32'h1000_0000, 32'h8000_0000, 1'b0);
		queue_orbit(32'h0000_0000, 32'h1000_0000, 32'hc000_0000, 1'b1);
		// table slot 1 and the top of quadrant one
		queue_orbit(32'h0000_0000, 32'h7fff_ffff, 32'h0010_0000, 1'b1);
		queue_orbit(32'h0000_0000, 32'h8000_0000, 32'h7ff0_0000, 1'b1);
		// golden-mean rotation, K = 1, three orbits
		queue_orbit(32'h09e3_779b, 32'h1000_0000, 32'h1234_5678, 1'b0);
		queue_orbit(32'h09e3_779b, 32'h1000_0000, 32'h9abc_def0, 1'b0);
		queue_orbit(32'h09e3_779b, 32'h1000_0000, 32'hffff_ffff, 1'b1);
		queue_orbit(32'hff00_0000, 32'h0800_0000, 32'h1234_5678, 1'b1);
		// smallest nonzero averages of both signs
		queue_orbit(32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 1'b1);
		queue_orbit(32'hffff_ffff, 32'h0000_0000, 32'h0000_0000, 1'b1);
		// exact half-LSB averages: round away from zero both ways
		queue_orbit(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
		queue_orbit(32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 1'b1);
		queue_orbit(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
		queue_orbit(32'hffff_ffff, 32'h0000_0000, 32'h0000_0000, 1'b1);

		// Random points. Most are well-formed: shared omega and K over a group
		// of orbits ending in last_orbit. Some carry full-range fields, some
		// extremes, and some are noise with random last flags.
		// The orbit-count limit needs over 65536 orbits per point, too long here.
		while (orbit_queue.size() < ITEM_TARGET) begin
			kind = $urandom_range(9);
			len  = ($urandom_range(9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
			freq = $urandom_range(0, 32'h1000_0000);
			k    = $urandom_range(0, 32'h3000_0000);
			if (kind == 8) begin
				freq = edge_value();
				k    = edge_value();
			end
			for (int n = 0; n < len; n++) begin
				if (kind == 6 || kind == 7) begin
					queue_orbit($urandom, $urandom, $urandom, n == len - 1);
				end else if (kind == 9) begin
					queue_orbit($urandom, $urandom, $urandom, 1'($urandom_range(1)));
				end else begin
					queue_orbit(freq, k, $urandom, n == len - 1);
				end
			end
		end
		// flush whatever point is still open
		orbit_queue[orbit_queue.size() - 1].last = 1'b1;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (orbit_queue.size() != 0 || winding_expected.size() != 0) begin
			@(posedge clk);
		end
		// catch any stray strobe after the last expected result
		repeat (RESULT_LATENCY + 40) @(posedge clk);

		$display("sent %0d orbits; checked %0d winding results, %0d of them saturated",
			orbits_sent, results_checked, saturations_seen);
		$display("%0d faults found", fault_count);
		if (fault_count == 0) begin
			$display("circle_map_winding_number test passed");
		end else begin
			$display("circle_map_winding_number test failed");
		end
		$finish;
	end

	// ~850 orbits with sender gaps: about 2.7M time units; allow several
	// times that
	initial begin : watchdog
		#16_000_000;
		$display("timeout: %0d orbits still pending, %0d results still owed",
			orbit_queue.size(), winding_expected.size());
		$display("circle_map_winding_number test failed");
		$finish;
	end

endmodule
